// ===== src/lasa_pkg.sv =====
// ----------------------------------------------------------------------------
// Skyline atlas allocator package
// Shared defaults, status and opcode codes, beat payload types and the
// command group that steers the window scan unit.
// ----------------------------------------------------------------------------
package lasa_pkg;

  localparam int PAGE_WIDTH_DEF  = 128;
  localparam int PAGE_HEIGHT_DEF = 128;
  localparam int NUM_PAGES_DEF   = 256;

  localparam logic       OP_ALLOC   = 1'b0;
  localparam logic       OP_CLEAR   = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_CLEARED = 2'd2;

  typedef struct packed {
    logic       op;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
  } lasa_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] page;
    logic [6:0] pos_x;
    logic [6:0] pos_y;
  } lasa_rsp_t;

  // Issue commands for the scan unit. Data for a p1 or p2 issue arrives from
  // the skyline memory in the cycle after the issue.
  typedef struct packed {
    logic start;
    logic p1;
    logic p2;
  } lasa_scan_cmd_t;

endpackage

// ===== src/lasa_scan.sv =====
// ----------------------------------------------------------------------------
// Skyline window scan unit
// Finds the lowest sliding-window maximum of one page's skyline, leftmost on
// ties, with a two-pass block decomposition: a right-to-left pass stores the
// block suffix maxima in a local memory, a left-to-right pass forms the block
// prefix maxima on the fly and combines both into each window's maximum.
// ----------------------------------------------------------------------------
module lasa_scan
  import lasa_pkg::*;
#(
  parameter int  PAGE_WIDTH  = PAGE_WIDTH_DEF,
  parameter int  PAGE_HEIGHT = PAGE_HEIGHT_DEF,
  localparam int COL_W       = $clog2(PAGE_WIDTH),
  localparam int HGT_W       = $clog2(PAGE_HEIGHT + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  lasa_scan_cmd_t   cmd,
  input  logic [COL_W-1:0] col,
  input  logic [COL_W-1:0] wm1,
  input  logic [HGT_W-1:0] hgt,
  output logic             found,
  output logic [HGT_W-1:0] best,
  output logic [COL_W-1:0] bx
);

  logic [HGT_W-1:0] aux_mem [PAGE_WIDTH];
  logic [HGT_W-1:0] aux_rd;

  logic [COL_W-1:0] wm1_q;
  logic [COL_W-1:0] blk_cnt;
  logic [COL_W-1:0] edge_cnt;
  logic [COL_W-1:0] st_cnt;
  logic [COL_W-1:0] s_col;
  logic [COL_W-1:0] s_st;
  logic             s_p1;
  logic             s_p2;
  logic             s_win;
  logic             s_rst;
  logic [HGT_W-1:0] suf;
  logic [HGT_W-1:0] pre;

  logic [HGT_W-1:0] suf_new;
  logic [HGT_W-1:0] pre_new;
  logic [HGT_W-1:0] top;
  logic [COL_W-1:0] cnt_cur;
  logic             win_i;

  always_comb begin
    suf_new = (blk_cnt == '0 || hgt > suf) ? hgt : suf;
    pre_new = (s_rst || hgt > pre) ? hgt : pre;
    top     = (aux_rd > pre_new) ? aux_rd : pre_new;
    // The first block of the forward pass is the partial one that the
    // backward pass left over; its size is what the block counter holds.
    cnt_cur = (col == '0) ? blk_cnt : edge_cnt;
    win_i   = (col >= wm1_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_p1  <= 1'b0;
      s_p2  <= 1'b0;
      found <= 1'b0;
    end else begin
      s_p1 <= cmd.p1;
      s_p2 <= cmd.p2;
      if (cmd.start) begin
        wm1_q   <= wm1;
        blk_cnt <= '0;
        st_cnt  <= '0;
        found   <= 1'b0;
        best    <= HGT_W'(PAGE_HEIGHT);
        bx      <= '0;
      end
      if (cmd.p1) begin
        s_col <= col;
      end
      if (cmd.p2) begin
        s_win    <= win_i;
        s_st     <= st_cnt;
        s_rst    <= (cnt_cur == '0) || (col == '0);
        edge_cnt <= (cnt_cur == '0) ? wm1_q : cnt_cur - 1'b1;
        if (win_i) begin
          st_cnt <= st_cnt + 1'b1;
        end
      end
      if (s_p1) begin
        suf     <= suf_new;
        blk_cnt <= (blk_cnt == wm1_q) ? '0 : blk_cnt + 1'b1;
      end
      if (s_p2) begin
        pre <= pre_new;
        if (s_win && top < best) begin
          best  <= top;
          bx    <= s_st;
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_p1) begin
      aux_mem[s_col] <= suf_new;
    end
    if (cmd.p2) begin
      aux_rd <= aux_mem[st_cnt];
    end
  end

endmodule

// ===== src/lightmap_atlas_skyline_allocator.sv =====
// ----------------------------------------------------------------------------
// Lightmap atlas skyline allocator
// Bottom-left skyline packing of rectangles into a set of square atlas pages,
// with all skylines held in one synchronous memory.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_stall   lasa_req_t (op, width, height)
//   rsp       out         rsp_valid / rsp_stall   lasa_rsp_t (status, page, x, y)
//
// An allocate beat visits pages from the remembered page on; each visited
// page runs a start state, a backward pass over the page's columns through
// the skyline memory port, a gap state, a forward pass, a drain state and a
// decision state, and a success adds one write per column of the rectangle.
// Requests that are too wide or too tall for a page, requests that arrive
// after the remembered page has run past the last page, and zero-width
// requests go straight to the done state without visiting a page.
// A clear beat, and reset itself, run a clearing pass over every column of
// every page in the skyline memory; no request beat is taken meanwhile.
// One request is in work at a time. The result sits in an output register,
// so a new request is taken while an earlier result is still stalled.

module lightmap_atlas_skyline_allocator
  import lasa_pkg::*;
#(
  parameter int PAGE_WIDTH  = PAGE_WIDTH_DEF,
  parameter int PAGE_HEIGHT = PAGE_HEIGHT_DEF,
  parameter int NUM_PAGES   = NUM_PAGES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  lasa_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output lasa_rsp_t rsp
);

  localparam int COL_W  = $clog2(PAGE_WIDTH);
  localparam int HGT_W  = $clog2(PAGE_HEIGHT + 1);
  localparam int PG_W   = $clog2(NUM_PAGES + 1);
  localparam int DEPTH  = NUM_PAGES * PAGE_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = ((HGT_W > 8) ? HGT_W : 8) + 1;
  localparam int WC_W   = ((COL_W + 1) > 8) ? (COL_W + 1) : 8;

  // Sequencer states.
  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_START  = 4'd2;
  localparam logic [3:0] S_P1     = 4'd3;
  localparam logic [3:0] S_GAP    = 4'd4;
  localparam logic [3:0] S_P2     = 4'd5;
  localparam logic [3:0] S_DRAIN  = 4'd6;
  localparam logic [3:0] S_DEC    = 4'd7;
  localparam logic [3:0] S_COMMIT = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]        state;
  logic [ADDR_W-1:0] clr_addr;
  logic              clr_rsp;
  logic [PG_W-1:0]   resume_page;
  logic [ADDR_W-1:0] resume_base;
  logic [PG_W-1:0]   page;
  logic [ADDR_W-1:0] base;
  logic [COL_W-1:0]  col_q;
  logic [COL_W-1:0]  cnt_q;
  logic [COL_W-1:0]  w_q;
  logic [7:0]        h_q;
  logic [HGT_W-1:0]  new_hgt;
  lasa_rsp_t         rsp_hold;

  // Skyline memory: one height per column of every page.
  logic [HGT_W-1:0]  sky_mem [DEPTH];
  logic [HGT_W-1:0]  sky_rd;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [HGT_W-1:0]  mem_wdata;

  lasa_scan_cmd_t    cmd;
  logic              scan_found;
  logic [HGT_W-1:0]  scan_best;
  logic [COL_W-1:0]  scan_bx;

  logic [WC_W-1:0]   req_w_ext;
  logic [SUM_W-1:0]  req_h_ext;
  logic              no_fit;
  logic [SUM_W-1:0]  fit_sum;
  logic              fit;

  assign req_stall = (state != S_IDLE);

  // A request that no page can take ends at once: the remembered page is
  // already past the end, the rectangle is at least a page wide, or it is
  // taller than a page.
  always_comb begin
    req_w_ext = WC_W'(req.rect_width);
    req_h_ext = SUM_W'(req.rect_height);
    no_fit    = (resume_page >= PG_W'(NUM_PAGES)) ||
                (req_w_ext >= WC_W'(PAGE_WIDTH)) ||
                (req_h_ext > SUM_W'(PAGE_HEIGHT));
    fit_sum   = SUM_W'(scan_best) + SUM_W'(h_q);
    fit       = scan_found && (fit_sum <= SUM_W'(PAGE_HEIGHT));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    mem_addr  = base + ADDR_W'(col_q);
    cmd       = '0;
    case (state)
      S_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      S_START: begin
        cmd.start = 1'b1;
      end
      S_P1: begin
        cmd.p1 = 1'b1;
      end
      S_P2: begin
        cmd.p2 = 1'b1;
      end
      S_COMMIT: begin
        mem_we    = 1'b1;
        mem_wdata = new_hgt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sky_mem[mem_addr] <= mem_wdata;
    end
    sky_rd <= sky_mem[mem_addr];
  end

  lasa_scan #(
    .PAGE_WIDTH  (PAGE_WIDTH),
    .PAGE_HEIGHT (PAGE_HEIGHT)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .col   (col_q),
    .wm1   (w_q - 1'b1),
    .hgt   (sky_rd),
    .found (scan_found),
    .best  (scan_best),
    .bx    (scan_bx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_addr    <= '0;
      clr_rsp     <= 1'b0;
      resume_page <= '0;
      resume_base <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      // The output register refills from the done state, possibly at the
      // same edge that hands its previous beat over.
      if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= clr_rsp ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            w_q <= COL_W'(req.rect_width);
            h_q <= req.rect_height;
            if (req.op == OP_CLEAR) begin
              clr_addr    <= '0;
              clr_rsp     <= 1'b1;
              resume_page <= '0;
              resume_base <= '0;
              rsp_hold    <= {ST_CLEARED, 8'd0, 7'd0, 7'd0};
              state       <= S_CLR;
            end else if (no_fit) begin
              resume_page <= PG_W'(NUM_PAGES);
              rsp_hold    <= {ST_FULL, 8'd0, 7'd0, 7'd0};
              state       <= S_DONE;
            end else if (req.rect_width == 8'd0) begin
              // An empty span lands at the left edge of the first page tried
              // and changes no column.
              rsp_hold <= {ST_OK, 8'(resume_page), 7'd0, 7'd0};
              state    <= S_DONE;
            end else begin
              page  <= resume_page;
              base  <= resume_base;
              state <= S_START;
            end
          end
        end
        S_START: begin
          col_q <= COL_W'(PAGE_WIDTH - 1);
          state <= S_P1;
        end
        S_P1: begin
          if (col_q == '0) begin
            state <= S_GAP;
          end else begin
            col_q <= col_q - 1'b1;
          end
        end
        S_GAP: begin
          col_q <= '0;
          state <= S_P2;
        end
        S_P2: begin
          // The last column is never a start, so the forward pass stops one
          // column short of the page edge.
          if (col_q == COL_W'(PAGE_WIDTH - 2)) begin
            state <= S_DRAIN;
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_DEC;
        end
        S_DEC: begin
          if (fit) begin
            new_hgt     <= HGT_W'(fit_sum);
            col_q       <= scan_bx;
            cnt_q       <= w_q;
            resume_page <= page;
            resume_base <= base;
            rsp_hold    <= {ST_OK, 8'(page), 7'(scan_bx), 7'(scan_best)};
            state       <= S_COMMIT;
          end else if (page == PG_W'(NUM_PAGES - 1)) begin
            resume_page <= PG_W'(NUM_PAGES);
            rsp_hold    <= {ST_FULL, 8'd0, 7'd0, 7'd0};
            state       <= S_DONE;
          end else begin
            page  <= page + 1'b1;
            base  <= base + ADDR_W'(PAGE_WIDTH);
            state <= S_START;
          end
        end
        S_COMMIT: begin
          col_q <= col_q + 1'b1;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == COL_W'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp   <= rsp_hold;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/lasa_chk.sv =====
// ----------------------------------------------------------------------------
// Skyline atlas allocator port checker
// Watches the request and result channels of the allocator over time.
// ----------------------------------------------------------------------------
module lasa_chk
  import lasa_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input lasa_req_t req,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input lasa_rsp_t rsp
);

  // A result that places nothing carries no page or position.
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |->
      (rsp.page == 8'd0 && rsp.pos_x == 7'd0 && rsp.pos_y == 7'd0))
    else $error("non-allocated result carries page or position");

  // Every request keeps the block busy for at least the following cycle.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request port open right after a request beat");

  // A new result only appears out of a busy cycle.
  a_rsp_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result appeared without work in progress");

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result changed or dropped");

endmodule

bind lightmap_atlas_skyline_allocator lasa_chk u_lasa_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Skyline atlas allocator testbench
// Drives allocate and clear beats into the allocator, predicts every placement
// with an independent skyline model, and checks each response beat in order
// under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module testbench;
  import lasa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = PAGE_WIDTH_DEF;
  localparam int PH = PAGE_HEIGHT_DEF;
  localparam int NP = NUM_PAGES_DEF;

  // The limit leaves ample headroom for the page visits and clearing passes
  // of a normal run.
  localparam int CYCLE_LIMIT      = 12000000;
  localparam int ITEMS_PER_PHASE  = 488;
  localparam int SETTLE_CYCLES    = 600;
  localparam int PRESSURE_CYCLES  = 3000;

  // Keeps a private copy of every skyline and the resume page, works out the
  // response for each accepted request, and holds those responses in order.
  class placement_book;
    int unsigned heights [NP*PW];
    int unsigned resume_page;
    lasa_rsp_t   pending[$];
    int          errors;

    function new();
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (heights[i]) heights[i] = 0;
      resume_page = 0;
    endfunction

    // Bottom-left skyline search. Starts run from 0 to PW-w-1; a start wins
    // only when strictly lower than the best so far, so ties go leftmost.
    function lasa_rsp_t place_rect(lasa_req_t r);
      lasa_rsp_t   res;
      int unsigned w, h, pg, s, j, top, best, bx, starts;
      bit          found;
      res = '0;
      w = r.rect_width;
      h = r.rect_height;
      if (r.op == OP_CLEAR) begin
        wipe();
        res.status = ST_CLEARED;
        return res;
      end
      starts = (w < PW) ? PW - w : 0;
      for (pg = resume_page; pg < NP; pg++) begin
        best  = PH;
        bx    = 0;
        found = 1'b0;
        for (s = 0; s < starts; s++) begin
          top = 0;
          for (j = 0; j < w; j++) begin
            if (heights[pg*PW + s + j] > top) top = heights[pg*PW + s + j];
          end
          if (top < best) begin
            best  = top;
            bx    = s;
            found = 1'b1;
          end
        end
        if (found && best + h <= PH) begin
          for (j = 0; j < w; j++) heights[pg*PW + bx + j] = best + h;
          resume_page = pg;
          res.status  = ST_OK;
          res.page    = pg[7:0];
          res.pos_x   = bx[6:0];
          res.pos_y   = best[6:0];
          return res;
        end
      end
      // Nothing fit: the resume page parks past the last page until a clear.
      resume_page = NP;
      res.status  = ST_FULL;
      return res;
    endfunction

    function void note_request(lasa_req_t r);
      pending.push_back(place_rect(r));
    endfunction

    task report_mismatch(string msg);
      if (errors < 200) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_placement(lasa_rsp_t got);
      lasa_rsp_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("response beat with nothing pending (status %0d)",
                                  got.status));
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
      if (got.page !== want.page)
        report_mismatch($sformatf("page %0d, wanted %0d", got.page, want.page));
      if (got.pos_x !== want.pos_x)
        report_mismatch($sformatf("pos_x %0d, wanted %0d", got.pos_x, want.pos_x));
      if (got.pos_y !== want.pos_y)
        report_mismatch($sformatf("pos_y %0d, wanted %0d", got.pos_y, want.pos_y));
    endtask
  endclass

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  lasa_req_t req;
  logic      rsp_valid;
  logic      rsp_stall;
  lasa_rsp_t rsp;

  placement_book book;

  // Idling knobs for the current phase, in percent per beat or per cycle.
  int sender_idle_pct;
  int receiver_stall_pct;
  // A nonzero value asks the receiver process to hold off for that many cycles.
  int hold_request;
  // After a request drawn to fit on no page, which parks the resume page, a
  // clear follows within a few beats so the rest of the run keeps placing rectangles.
  int clear_countdown;
  int cycle_count;

  lightmap_atlas_skyline_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: the run must be over well before this count.
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("testbench: done, errors");
    $finish;
  end

  // Both channels are sampled at the edge, before any update of that edge
  // lands, so a beat counts exactly when valid is high and stall is low.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) book.note_request(req);
      if (rsp_valid && !rsp_stall) book.check_placement(rsp);
    end
  end

  // Response side. Besides the per-cycle random stall there are occasional
  // long stretches, and the one long hold-off that backs the block up.
  initial begin
    int hold_left;
    int stretch_left;
    rsp_stall    = 1'b0;
    hold_left    = 0;
    stretch_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (stretch_left > 0) begin
        stretch_left--;
        rsp_stall <= 1'b1;
      end else if (receiver_stall_pct > 0 && $urandom_range(199) == 0) begin
        stretch_left = $urandom_range(300, 1);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  function automatic lasa_req_t make_req(logic op, int w, int h);
    lasa_req_t r;
    r.op          = op;
    r.rect_width  = 8'(w);
    r.rect_height = 8'(h);
    return r;
  endfunction

  // Offers one request beat and returns in the step of the edge that took it.
  // Entered in the step of a rising edge, so valid gets one assignment there:
  // either it drops for a gap or it carries the new payload straight away.
  task automatic offer_request(input lasa_req_t item);
    int gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct)
      gap = ($urandom_range(15) == 0) ? $urandom_range(300, 1) : $urandom_range(3, 1);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
  endtask

  // Hand-picked beats: field extremes, both operations, zero width, zero
  // height, widths that leave no start, the skipped last start column, a
  // height that fits on no page, and requests after the resume page parked.
  task automatic run_directed();
    offer_request(make_req(OP_ALLOC, 1, 1));
    offer_request(make_req(OP_ALLOC, 0, 5));
    offer_request(make_req(OP_ALLOC, 0, 0));
    offer_request(make_req(OP_ALLOC, 10, 0));
    offer_request(make_req(OP_ALLOC, 127, 128));
    offer_request(make_req(OP_ALLOC, 128, 0));
    offer_request(make_req(OP_ALLOC, 255, 255));
    offer_request(make_req(OP_ALLOC, 1, 1));
    offer_request(make_req(OP_CLEAR, 255, 255));
    // A full-height slab over all but the last column, then a one-wide
    // column that could only go in that last column and so moves on.
    offer_request(make_req(OP_ALLOC, 127, 128));
    offer_request(make_req(OP_ALLOC, 1, 128));
    offer_request(make_req(OP_ALLOC, 1, 1));
    // Too tall for any page: the request ends at once and parks the resume page.
    offer_request(make_req(OP_ALLOC, 2, 200));
    offer_request(make_req(OP_CLEAR, 0, 0));
    offer_request(make_req(OP_ALLOC, 64, 64));
    offer_request(make_req(OP_ALLOC, 64, 64));
    offer_request(make_req(OP_ALLOC, 128, 1));
    offer_request(make_req(OP_CLEAR, 128, 128));
    offer_request(make_req(OP_ALLOC, 1, 128));
    offer_request(make_req(OP_ALLOC, 127, 1));
    offer_request(make_req(OP_ALLOC, 8, 8));
    offer_request(make_req(OP_ALLOC, 16, 4));
  endtask

  // Mostly well-formed allocations of mixed sizes, with a little noise:
  // requests that fit nowhere, zero sizes and the odd spontaneous clear.
  function automatic lasa_req_t next_random_request();
    lasa_req_t r;
    int        pick;
    r.op          = OP_ALLOC;
    r.rect_width  = 8'($urandom_range(255));
    r.rect_height = 8'($urandom_range(255));
    if (clear_countdown == 0) begin
      clear_countdown = -1;
      r.op = OP_CLEAR;
      return r;
    end
    if (clear_countdown > 0) clear_countdown--;
    pick = $urandom_range(999);
    if (pick < 1) begin
      r.op = OP_CLEAR;
      clear_countdown = -1;
    end else if (pick < 5) begin
      // No start column exists on any page.
      r.rect_width = 8'($urandom_range(255, PW));
      if (clear_countdown < 0) clear_countdown = $urandom_range(6);
    end else if (pick < 6) begin
      // Taller than any page.
      r.rect_width  = 8'($urandom_range(PW - 1));
      r.rect_height = 8'($urandom_range(255, PH + 1));
      if (clear_countdown < 0) clear_countdown = $urandom_range(6);
    end else if (pick < 16) begin
      r.rect_width  = 8'(0);
      r.rect_height = 8'($urandom_range(PH));
    end else if (pick < 26) begin
      r.rect_width  = 8'($urandom_range(PW - 1, 1));
      r.rect_height = 8'(0);
    end else if (pick < 700) begin
      r.rect_width  = 8'($urandom_range(16, 1));
      r.rect_height = 8'($urandom_range(16, 1));
    end else if (pick < 920) begin
      r.rect_width  = 8'($urandom_range(64, 1));
      r.rect_height = 8'($urandom_range(64, 1));
    end else begin
      r.rect_width  = 8'($urandom_range(PW - 1, 1));
      r.rect_height = 8'($urandom_range(PH, 1));
    end
    return r;
  endfunction

  initial begin
    int phase;
    int n;
    book               = new();
    rst                = 1'b1;
    req_valid          = 1'b0;
    req                = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_request       = 0;
    clear_countdown    = -1;

    // Reset once; the block then runs its own clearing pass and holds off
    // request beats until that is done.
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    // Phases: no idling, sender idle, receiver stalling, then both.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 51;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 51;
        end
        default: begin
          sender_idle_pct    = 36;
          receiver_stall_pct = 36;
        end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Long receiver hold-off while requests keep coming, so the output
        // register fills, the next result backs up and the input stalls.
        if (phase == 0 && n == 40) hold_request = PRESSURE_CYCLES;
        offer_request(next_random_request());
      end
    end
    req_valid <= 1'b0;

    // Drain: every request yields one response, then idle a while to catch
    // any stray response beat.
    while (book.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (book.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
